/* rtl/pmst_pkg.sv */
// Shared types and defaults for the Prim minimum spanning tree block.
// No dependencies; used by rtl/prim_mst_dense_matrix.sv.
package pmst_pkg;

  localparam int VERTICES_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam int OUT_MAX         = 15;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RELAX = 2'd1,
    ST_EMIT  = 2'd2
  } state_t;

endpackage

/* rtl/pmst_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/prim_mst_dense_matrix.sv */
// Prim minimum spanning tree over a dense adjacency matrix, rooted at vertex 0.
// Load: one matrix entry per cycle while busy is low; the entry marked last starts a run.
// Run: up to VERTICES rounds (one key-RAM read per vertex per round), then one result
// per cycle for vertices 1..min(VERTICES-1,15).
// Reset (rst_n low, synchronous) returns to loading; the matrix RAM keeps its contents.
module prim_mst_dense_matrix #(
  parameter int VERTICES    = pmst_pkg::VERTICES_DEF,
  parameter int WEIGHT_BITS = pmst_pkg::WEIGHT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic [15:0] in_weight,
  input  logic        in_last,
  output logic        out_valid,
  output logic [3:0]  out_parent,
  output logic [3:0]  out_child,
  output logic [15:0] out_edge_weight,
  output logic        out_reachable,
  output logic        out_last_res
);

  localparam int VB      = $clog2(VERTICES);
  localparam int WB      = WEIGHT_BITS;
  localparam int OUT_CNT = (VERTICES - 1 > pmst_pkg::OUT_MAX) ? pmst_pkg::OUT_MAX
                                                               : VERTICES - 1;
  localparam int ADJ_DEPTH = 1 << (2 * VB);
  localparam int KEY_DEPTH = 1 << VB;
  localparam logic [WB:0] KEY_INF = {1'b1, {WB{1'b0}}};

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  pmst_pkg::state_t state_r, state_nxt;

  logic [VB:0]         iss_cnt_r, iss_cnt_nxt;   // next vertex whose RAM read is issued
  logic                s1_vld_r, s1_vld_nxt;     // RAM read data valid this cycle
  logic [VB-1:0]       s1_idx_r, s1_idx_nxt;     // vertex the read data belongs to
  logic [VB-1:0]       pick_r, pick_nxt;         // vertex added this round
  logic [WB:0]         low_r, low_nxt;           // running minimum key for next pick
  logic [VB-1:0]       best_r, best_nxt;
  logic                found_r, found_nxt;
  logic [VERTICES-1:0] in_tree_r, in_tree_nxt;
  logic [VERTICES-1:0] kvalid_r, kvalid_nxt;     // key entry written this run

  logic                out_valid_r, out_valid_nxt;
  logic [3:0]          out_parent_r, out_parent_nxt;
  logic [3:0]          out_child_r, out_child_nxt;
  logic [15:0]         out_weight_r, out_weight_nxt;
  logic                out_reach_r, out_reach_nxt;
  logic                out_last_r, out_last_nxt;

  // ---------------------------------------------------------------------------
  // Load side: a transaction is taken when start is high and busy is low
  // ---------------------------------------------------------------------------
  logic          accept;
  logic [7:0]    row8, col8;
  logic          in_range;
  logic [31:0]   w_in32;
  logic [WB-1:0] w_in;

  assign accept   = start && (state_r == pmst_pkg::ST_IDLE);
  assign row8     = 8'(in_row);
  assign col8     = 8'(in_col);
  // drop entries outside the matrix; their last mark still starts the run
  assign in_range = (row8 < 8'(VERTICES)) && (col8 < 8'(VERTICES));
  assign w_in32   = 32'(in_weight);
  assign w_in     = w_in32[WB-1:0];

  // ---------------------------------------------------------------------------
  // Memories: adjacency matrix, and per-vertex {parent, key}
  // ---------------------------------------------------------------------------
  logic [WB-1:0]    adj_rd;
  logic [WB+VB-1:0] key_rd;
  logic             key_we;
  logic [VB-1:0]    rd_idx;

  assign rd_idx = iss_cnt_r[VB-1:0];

  pmst_ram #(
    .WIDTH (WB),
    .DEPTH (ADJ_DEPTH)
  ) u_adj_ram (
    .clk   (clk),
    .we    (accept && in_range),
    .waddr ({row8[VB-1:0], col8[VB-1:0]}),
    .wdata (w_in),
    .raddr ({pick_r, rd_idx}),
    .rdata (adj_rd)
  );

  pmst_ram #(
    .WIDTH (WB + VB),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (s1_idx_r),
    .wdata ({pick_r, adj_rd}),
    .raddr (rd_idx),
    .rdata (key_rd)
  );

  // ---------------------------------------------------------------------------
  // Shared relax/compare unit: one vertex per cycle. It lowers the key of the
  // vertex in flight and, in the same step, tracks the smallest key outside
  // the tree (strict compare in ascending order keeps the lowest index on ties).
  // ---------------------------------------------------------------------------
  logic [WB-1:0] kv;
  logic [VB-1:0] kpar;
  logic [WB:0]   kv_ext, w_ext, new_ext;
  logic          s1_in_tree, s1_kvalid, upd, cand;
  logic          pass_end, found_f, emit_end, issue_relax, issue_emit;
  logic [VB-1:0] best_f;
  logic [31:0]   kv32;
  logic [7:0]    kpar8, idx8;

  assign kv         = key_rd[WB-1:0];
  assign kpar       = key_rd[WB+VB-1:WB];
  assign s1_in_tree = in_tree_r[s1_idx_r];
  assign s1_kvalid  = kvalid_r[s1_idx_r];
  // an entry not written this run holds infinity
  assign kv_ext     = s1_kvalid ? {1'b0, kv} : KEY_INF;
  assign w_ext      = {1'b0, adj_rd};
  assign upd        = (adj_rd != '0) && !s1_in_tree && (w_ext < kv_ext);
  assign new_ext    = upd ? w_ext : kv_ext;
  assign cand       = !s1_in_tree && (new_ext < low_r);

  assign issue_relax = (state_r == pmst_pkg::ST_RELAX) && (iss_cnt_r < (VB+1)'(VERTICES));
  assign issue_emit  = (state_r == pmst_pkg::ST_EMIT) && (iss_cnt_r <= (VB+1)'(OUT_CNT));
  assign pass_end    = (state_r == pmst_pkg::ST_RELAX) && s1_vld_r
                       && (s1_idx_r == VB'(VERTICES - 1));
  assign emit_end    = (state_r == pmst_pkg::ST_EMIT) && s1_vld_r
                       && (s1_idx_r == VB'(OUT_CNT));
  assign found_f     = found_r || cand;
  assign best_f      = cand ? s1_idx_r : best_r;
  assign key_we      = (state_r == pmst_pkg::ST_RELAX) && s1_vld_r && upd;

  assign kv32  = 32'(kv);
  assign kpar8 = 8'(kpar);
  assign idx8  = 8'(s1_idx_r);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmst_pkg::ST_IDLE: begin
        if (accept && in_last) begin
          state_nxt = pmst_pkg::ST_RELAX;
        end
      end
      pmst_pkg::ST_RELAX: begin
        // no finite key left outside the tree: the tree is complete
        if (pass_end && !found_f) begin
          state_nxt = pmst_pkg::ST_EMIT;
        end
      end
      pmst_pkg::ST_EMIT: begin
        if (emit_end) begin
          state_nxt = pmst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pmst_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    iss_cnt_nxt    = iss_cnt_r;
    s1_vld_nxt     = 1'b0;
    s1_idx_nxt     = rd_idx;
    pick_nxt       = pick_r;
    low_nxt        = low_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    in_tree_nxt    = in_tree_r;
    kvalid_nxt     = kvalid_r;
    out_valid_nxt  = 1'b0;
    out_parent_nxt = out_parent_r;
    out_child_nxt  = out_child_r;
    out_weight_nxt = out_weight_r;
    out_reach_nxt  = out_reach_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      pmst_pkg::ST_IDLE: begin
        if (accept && in_last) begin
          // fresh run: vertex 0 joins the tree first
          iss_cnt_nxt = '0;
          pick_nxt    = '0;
          low_nxt     = KEY_INF;
          found_nxt   = 1'b0;
          in_tree_nxt = VERTICES'(1);
          kvalid_nxt  = '0;
        end
      end
      pmst_pkg::ST_RELAX: begin
        if (issue_relax) begin
          s1_vld_nxt  = 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (s1_vld_r) begin
          if (upd) begin
            kvalid_nxt[s1_idx_r] = 1'b1;
          end
          if (cand) begin
            low_nxt   = new_ext;
            best_nxt  = s1_idx_r;
            found_nxt = 1'b1;
          end
        end
        if (pass_end) begin
          low_nxt   = KEY_INF;
          found_nxt = 1'b0;
          if (found_f) begin
            // add the chosen vertex and start the next round
            pick_nxt             = best_f;
            in_tree_nxt[best_f]  = 1'b1;
            iss_cnt_nxt          = '0;
          end else begin
            iss_cnt_nxt = (VB+1)'(1);
          end
        end
      end
      pmst_pkg::ST_EMIT: begin
        if (issue_emit) begin
          s1_vld_nxt  = 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (s1_vld_r) begin
          out_valid_nxt  = 1'b1;
          out_child_nxt  = idx8[3:0];
          out_reach_nxt  = s1_kvalid;
          out_parent_nxt = s1_kvalid ? kpar8[3:0] : 4'd0;
          out_weight_nxt = s1_kvalid ? kv32[15:0] : 16'd0;
          out_last_nxt   = emit_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmst_pkg::ST_IDLE;
      iss_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      pick_r      <= '0;
      low_r       <= KEY_INF;
      best_r      <= '0;
      found_r     <= 1'b0;
      in_tree_r   <= '0;
      kvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      s1_vld_r    <= s1_vld_nxt;
      pick_r      <= pick_nxt;
      low_r       <= low_nxt;
      best_r      <= best_nxt;
      found_r     <= found_nxt;
      in_tree_r   <= in_tree_nxt;
      kvalid_r    <= kvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk) begin
    s1_idx_r     <= s1_idx_nxt;
    out_parent_r <= out_parent_nxt;
    out_child_r  <= out_child_nxt;
    out_weight_r <= out_weight_nxt;
    out_reach_r  <= out_reach_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy            = (state_r != pmst_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_parent      = out_parent_r;
  assign out_child       = out_child_r;
  assign out_edge_weight = out_weight_r;
  assign out_reachable   = out_reach_r;
  assign out_last_res    = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_res |-> !busy)
    else $error("final result transaction while still busy");

  a_root_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmst_pkg::ST_RELAX) |-> in_tree_r[0])
    else $error("root vertex missing from tree during relax");

  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> (out_parent == 4'd0) && (out_edge_weight == 16'd0))
    else $error("unreachable vertex reported with nonzero parent or weight");

  a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last |=> busy && !out_valid)
    else $error("last entry did not start a run");
`endif

endmodule
